FILE: rtl/nsf_pkg.sv
`default_nettype none

package nsf_pkg;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] PRINT_LO    = 8'h20;
  localparam logic [7:0] PRINT_HI    = 8'h7E;

  localparam int unsigned LimitW    = 10;
  localparam int unsigned CountW    = 16;
  localparam int unsigned ScaledW   = 26;
  localparam logic [LimitW-1:0] LIMIT_RESET = 10'd10;
  localparam logic [9:0] MS_PER_SEC = 10'd1000;

  typedef enum logic [2:0] {
    EV_APPENDED  = 3'd0,
    EV_STARTED   = 3'd1,
    EV_CR_IGNORE = 3'd2,
    EV_COMPLETE  = 3'd3,
    EV_RESTARTED = 3'd4,
    EV_OVERFLOW  = 3'd5,
    EV_STRAY     = 3'd6
  } event_t;

  function automatic logic [7:0] hex_upper(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h41 + {4'd0, nib} - 8'd10;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/nsf_if.sv
`default_nettype none

interface nsf_rx_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] now_ms;

  modport source (output valid, output rx_byte, output now_ms, input ready);
  modport sink (input valid, input rx_byte, input now_ms, output ready);
endinterface

interface nsf_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        appended;
  logic [2:0]  event_res;
  logic        checksum_ok;
  logic [31:0] start_time;
  logic        invert_request;

  modport source (
    output valid, output data_byte, output appended, output event_res,
    output checksum_ok, output start_time, output invert_request, input ready
  );
  modport sink (
    input valid, input data_byte, input appended, input event_res,
    input checksum_ok, input start_time, input invert_request, output ready
  );
endinterface

`default_nettype wire

FILE: rtl/nmea0183_sentence_framer_top.sv
`default_nettype none

// channel  | dir | payload                                         | accepted when
// rx       | in  | rx_byte, now_ms                                 | valid & ready
// res      | out | data_byte, appended, event_res, checksum_ok,    | valid & ready
//          |     | start_time, invert_request                      |
// cfg      | in  | cfg_wr_data (bad start rate limit)              | cfg_wr_en
//
// one item per cycle while the result side is not stalled; an item passes the input register then the result register
// the framing state and the bad start rate test (one 11 x 26 multiply) sit between them
// rst clears all framing state, the bad start window, and sets the limit to 10
// a stalled result holds; the input register takes at most one more item and then holds rx off
module nmea0183_sentence_framer_top #(
  parameter int MAX_SENTENCE = 128
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [nsf_pkg::LimitW-1:0] cfg_wr_data,
  nsf_rx_if.sink                         rx,
  nsf_res_if.source                      res
);
  import nsf_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_SENTENCE + 1);
  localparam logic [LenW-1:0] LEN_MAX = LenW'(MAX_SENTENCE);
  localparam logic [LenW-1:0] LEN_ONE = LenW'(1);

  logic [LimitW-1:0] limit;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic [31:0] s1_now;
  logic        advance;

  logic              capturing, capturing_next;
  logic [LenW-1:0]   sent_len, sent_len_next;
  logic [31:0]       start_time, start_time_next;
  logic [7:0]        run_xor, run_xor_next;
  logic              star_seen, star_seen_next;
  logic [1:0]        digits, digits_next;
  logic              check_failed, check_failed_next;
  logic [CountW-1:0] bad_count, bad_count_next;
  logic [31:0]       window_start, window_start_next;

  logic              r_appended, r_ok, r_inv;
  event_t            r_event;

  logic [CountW-1:0]        count_inc;
  logic [31:0]              elapsed_raw;
  logic [ScaledW-1:0]       elapsed;
  logic                     elapsed_big;
  logic [ScaledW-1:0]       scaled_count;
  logic [ScaledW+LimitW:0]  rhs;
  logic                     rate_fire;
  logic [7:0]               exp_digit;

  assign advance  = s1_valid && (!res.valid || res.ready);
  assign rx.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
      s1_now  <= rx.now_ms;
    end
  end

  // bad start rate test
  always_comb begin
    count_inc = bad_count;
    if (s1_byte[7] && (bad_count != {CountW{1'b1}})) begin
      count_inc = bad_count + CountW'(1);
    end
    elapsed_raw  = s1_now - window_start;
    elapsed_big  = |elapsed_raw[31:ScaledW];
    elapsed      = (elapsed_raw == 32'd0) ? ScaledW'(1) : elapsed_raw[ScaledW-1:0];
    scaled_count = ScaledW'(count_inc) * ScaledW'(MS_PER_SEC);
    rhs          = (ScaledW+LimitW+1)'({1'b0, limit} + (LimitW+1)'(1)) *
                   (ScaledW+LimitW+1)'(elapsed);
    rate_fire    = !elapsed_big && ({(LimitW+1)'(0), scaled_count} >= rhs);
  end

  assign exp_digit = (digits == 2'd0) ? hex_upper(run_xor[7:4]) : hex_upper(run_xor[3:0]);

  always_comb begin
    capturing_next    = capturing;
    sent_len_next     = sent_len;
    start_time_next   = start_time;
    run_xor_next      = run_xor;
    star_seen_next    = star_seen;
    digits_next       = digits;
    check_failed_next = check_failed;
    bad_count_next    = bad_count;
    window_start_next = window_start;
    r_appended        = 1'b0;
    r_ok              = 1'b0;
    r_inv             = 1'b0;
    r_event           = EV_APPENDED;

    if (!capturing) begin
      if (s1_byte == CHAR_DOLLAR) begin
        capturing_next    = 1'b1;
        sent_len_next     = LEN_ONE;
        start_time_next   = s1_now;
        run_xor_next      = 8'd0;
        star_seen_next    = 1'b0;
        digits_next       = 2'd0;
        check_failed_next = 1'b0;
        r_appended        = 1'b1;
        r_event           = EV_STARTED;
      end else begin
        r_event        = EV_STRAY;
        bad_count_next = count_inc;
        if (rate_fire) begin
          r_inv             = 1'b1;
          bad_count_next    = '0;
          window_start_next = s1_now;
        end
      end
    end else begin
      priority if (s1_byte == CHAR_LF) begin
        r_event        = EV_COMPLETE;
        r_ok           = star_seen && (digits == 2'd2) && !check_failed;
        capturing_next = 1'b0;
      end else if (s1_byte == CHAR_CR) begin
        r_event = EV_CR_IGNORE;
      end else if (s1_byte == CHAR_DOLLAR) begin
        sent_len_next     = LEN_ONE;
        start_time_next   = s1_now;
        run_xor_next      = 8'd0;
        star_seen_next    = 1'b0;
        digits_next       = 2'd0;
        check_failed_next = 1'b0;
        r_appended        = 1'b1;
        r_event           = EV_RESTARTED;
      end else if (sent_len < LEN_MAX) begin
        sent_len_next = sent_len + LEN_ONE;
        r_appended    = 1'b1;
        r_event       = EV_APPENDED;
        if (!star_seen) begin
          if (s1_byte == CHAR_STAR) begin
            star_seen_next = 1'b1;
          end else begin
            if (s1_byte < PRINT_LO || s1_byte > PRINT_HI) begin
              check_failed_next = 1'b1;
            end
            run_xor_next = run_xor ^ s1_byte;
          end
        end else begin
          if (digits == 2'd3 || digits == 2'd2 || s1_byte != exp_digit) begin
            check_failed_next = 1'b1;
          end
          if (digits != 2'd3) begin
            digits_next = digits + 2'd1;
          end
        end
      end else begin
        r_event        = EV_OVERFLOW;
        capturing_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capturing    <= 1'b0;
      sent_len     <= '0;
      start_time   <= 32'd0;
      run_xor      <= 8'd0;
      star_seen    <= 1'b0;
      digits       <= 2'd0;
      check_failed <= 1'b0;
      bad_count    <= '0;
      window_start <= 32'd0;
    end else if (advance) begin
      capturing    <= capturing_next;
      sent_len     <= sent_len_next;
      start_time   <= start_time_next;
      run_xor      <= run_xor_next;
      star_seen    <= star_seen_next;
      digits       <= digits_next;
      check_failed <= check_failed_next;
      bad_count    <= bad_count_next;
      window_start <= window_start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.data_byte      <= s1_byte;
      res.appended       <= r_appended;
      res.event_res      <= r_event;
      res.checksum_ok    <= r_ok;
      res.start_time     <= start_time_next;
      res.invert_request <= r_inv;
    end
  end

endmodule

`default_nettype wire

FILE: tb/nmea0183_sentence_framer_top_tb.sv
module nmea0183_sentence_framer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nsf_pkg::*;

  localparam int MaxSentence = 128;
  localparam int HoldCycles = 64;
  localparam int PhaseItems = 190;
  localparam int ScriptLen = 25;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        appended;
    event_t      ev;
    logic        checksum_ok;
    logic [31:0] start_time;
    logic        invert_request;
  } framer_res_t;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
    logic        pinned;
    framer_res_t res;
  } script_row_t;

  localparam framer_res_t NoRes = '0;

  // pinned rows carry the result typed in, the rest go through the predictor
  localparam script_row_t DirectedScript [ScriptLen] = '{
    '{8'h41, 32'd0, 1'b1, '{8'h41, 1'b0, EV_STRAY, 1'b0, 32'd0, 1'b0}},
    '{8'hFF, 32'd0, 1'b1, '{8'hFF, 1'b0, EV_STRAY, 1'b0, 32'd0, 1'b1}},
    '{8'h80, 32'hFFFF_FFFF, 1'b1, '{8'h80, 1'b0, EV_STRAY, 1'b0, 32'd0, 1'b0}},
    '{8'h24, 32'hFFFF_FFFF, 1'b1,
      '{8'h24, 1'b1, EV_STARTED, 1'b0, 32'hFFFF_FFFF, 1'b0}},
    '{8'h0D, 32'd0, 1'b1, '{8'h0D, 1'b0, EV_CR_IGNORE, 1'b0, 32'hFFFF_FFFF, 1'b0}},
    '{8'h24, 32'd5, 1'b1, '{8'h24, 1'b1, EV_RESTARTED, 1'b0, 32'd5, 1'b0}},
    '{8'h47, 32'd6, 1'b0, NoRes},
    '{8'h50, 32'd7, 1'b0, NoRes},
    '{8'h2A, 32'd8, 1'b0, NoRes},
    '{8'h31, 32'd9, 1'b0, NoRes},
    '{8'h37, 32'd10, 1'b0, NoRes},
    '{8'h0A, 32'd11, 1'b0, NoRes},
    '{8'h00, 32'd12, 1'b0, NoRes},
    '{8'h24, 32'd13, 1'b0, NoRes},
    '{8'h4A, 32'd14, 1'b0, NoRes},
    '{8'h2A, 32'd15, 1'b0, NoRes},
    '{8'h34, 32'd16, 1'b0, NoRes},
    '{8'h61, 32'd17, 1'b0, NoRes},
    '{8'h0A, 32'd18, 1'b0, NoRes},
    '{8'h24, 32'd19, 1'b0, NoRes},
    '{8'h01, 32'd20, 1'b0, NoRes},
    '{8'h2A, 32'd21, 1'b0, NoRes},
    '{8'h30, 32'd22, 1'b0, NoRes},
    '{8'h31, 32'd23, 1'b0, NoRes},
    '{8'h0A, 32'd24, 1'b0, NoRes}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [LimitW-1:0] cfg_wr_data;

  nsf_rx_if rx_ch ();
  nsf_res_if res_ch ();

  nmea0183_sentence_framer_top #(
    .MAX_SENTENCE(MaxSentence)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .rx(rx_ch),
    .res(res_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // framer state as predicted
  logic [LimitW-1:0] rate_limit;
  logic              cap_active;
  logic [7:0]        body_len;
  logic [31:0]       sent_start_ms;
  logic [7:0]        body_xor;
  logic              star_hit;
  logic [1:0]        hex_count;
  logic              body_bad;
  logic [15:0]       bad_starts;
  logic [31:0]       window_ms;

  framer_res_t pending_results[$];
  int          errors = 0;
  int          items_sent = 0;
  logic [31:0] clock_ms = 32'd0;
  bit          rx_gaps_on = 1'b0;
  bit          res_stalls_on = 1'b0;
  bit          res_hold_req = 1'b0;

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
    if (nib < 4'd10) begin
      return 8'h30 + {4'd0, nib};
    end
    return (lower ? 8'h61 : 8'h41) + {4'd0, nib} - 8'd10;
  endfunction

  function automatic void open_body(input logic [31:0] t);
    cap_active = 1'b1;
    body_len = 8'd1;
    sent_start_ms = t;
    body_xor = 8'd0;
    star_hit = 1'b0;
    hex_count = 2'd0;
    body_bad = 1'b0;
  endfunction

  function automatic framer_res_t frame_byte(input logic [7:0] b, input logic [31:0] t);
    framer_res_t r;
    logic [31:0] elapsed;
    longint unsigned scaled_count;
    longint unsigned scaled_window;
    logic [3:0] nib;
    r = NoRes;
    r.data_byte = b;
    r.ev = EV_APPENDED;
    if (!cap_active) begin
      if (b == CHAR_DOLLAR) begin
        open_body(t);
        r.appended = 1'b1;
        r.ev = EV_STARTED;
      end else begin
        r.ev = EV_STRAY;
        if (b[7] && bad_starts != 16'hFFFF) begin
          bad_starts = bad_starts + 16'd1;
        end
        elapsed = t - window_ms;
        if (elapsed == 32'd0) begin
          elapsed = 32'd1;
        end
        scaled_count = 64'(bad_starts);
        scaled_count = scaled_count * 64'd1000;
        scaled_window = 64'(rate_limit);
        scaled_window = (scaled_window + 64'd1) * 64'(elapsed);
        if (scaled_count >= scaled_window) begin
          r.invert_request = 1'b1;
          bad_starts = 16'd0;
          window_ms = t;
        end
      end
    end else if (b == CHAR_LF) begin
      r.ev = EV_COMPLETE;
      r.checksum_ok = star_hit && hex_count == 2'd2 && !body_bad;
      cap_active = 1'b0;
    end else if (b == CHAR_CR) begin
      r.ev = EV_CR_IGNORE;
    end else if (b == CHAR_DOLLAR) begin
      open_body(t);
      r.appended = 1'b1;
      r.ev = EV_RESTARTED;
    end else if (body_len < 8'(MaxSentence)) begin
      body_len = body_len + 8'd1;
      r.appended = 1'b1;
      if (!star_hit) begin
        if (b == CHAR_STAR) begin
          star_hit = 1'b1;
        end else begin
          if (b < PRINT_LO || b > PRINT_HI) begin
            body_bad = 1'b1;
          end
          body_xor = body_xor ^ b;
        end
      end else begin
        if (hex_count < 2'd2) begin
          nib = (hex_count == 2'd0) ? body_xor[7:4] : body_xor[3:0];
          if (b != hex_char(nib, 1'b0)) begin
            body_bad = 1'b1;
          end
        end else begin
          body_bad = 1'b1;
        end
        if (hex_count != 2'd3) begin
          hex_count = hex_count + 2'd1;
        end
      end
    end else begin
      r.ev = EV_OVERFLOW;
      cap_active = 1'b0;
    end
    r.start_time = sent_start_ms;
    return r;
  endfunction

  function automatic void field_check(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    framer_res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with none expected, expected none actual data_byte %0h",
                 $time, res_ch.data_byte);
        errors++;
      end else begin
        want = pending_results.pop_front();
        field_check("data_byte", 32'(want.data_byte), 32'(res_ch.data_byte));
        field_check("appended", 32'(want.appended), 32'(res_ch.appended));
        field_check("event_res", 32'(want.ev), 32'(res_ch.event_res));
        field_check("checksum_ok", 32'(want.checksum_ok), 32'(res_ch.checksum_ok));
        field_check("start_time", want.start_time, res_ch.start_time);
        field_check("invert_request", 32'(want.invert_request),
                    32'(res_ch.invert_request));
      end
    end
  end

  // result side: random stall bursts, plus one long hold when asked
  initial begin : drive_ready
    int k;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (res_hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        res_hold_req = 1'b0;
      end else if (res_stalls_on && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        k = $urandom_range(1, 11);
        repeat (k - 1) @(negedge clk);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer_byte(input logic [7:0] b, input logic [31:0] t, input bit pinned,
                            input framer_res_t pinned_res);
    framer_res_t r;
    if (rx_gaps_on && $urandom_range(0, 7) == 0) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    rx_ch.now_ms <= t;
    do @(posedge clk); while (!rx_ch.ready);
    r = frame_byte(b, t);
    pending_results.push_back(pinned ? pinned_res : r);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] tick_ms();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      clock_ms = clock_ms + $urandom_range(0, 2);
    end else if (pick < 99) begin
      clock_ms = clock_ms + $urandom_range(3, 400);
    end else begin
      clock_ms = $urandom;
    end
    return clock_ms;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    offer_byte(b, tick_ms(), 1'b0, NoRes);
  endtask

  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do c = 8'($urandom_range(PRINT_LO, PRINT_HI));
    while (c == CHAR_STAR || c == CHAR_DOLLAR);
    return c;
  endfunction

  task automatic drain_results();
    rx_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    rate_limit = v;
  endtask

  // flaw: 0 wrong digit, 1 lowercase, 2 third digit, 3 no star,
  // 4 non-printable byte in body, 5 restart in body, 6 one digit; -1 clean
  task automatic send_sentence(input int flaw);
    logic [7:0] sum;
    logic [7:0] c;
    int n;
    int i;
    sum = 8'd0;
    n = $urandom_range(0, 20);
    send_byte(CHAR_DOLLAR);
    for (i = 0; i < n; i++) begin
      if (i == n / 2 && flaw == 4) begin
        do c = 8'($urandom_range(0, 255));
        while ((c >= PRINT_LO && c <= PRINT_HI) || c == CHAR_LF || c == CHAR_CR);
        send_byte(c);
      end
      if (i == n / 2 && flaw == 5) begin
        send_byte(CHAR_DOLLAR);
        sum = 8'd0;
      end
      c = body_char();
      sum = sum ^ c;
      send_byte(c);
    end
    if (flaw != 3) begin
      send_byte(CHAR_STAR);
    end
    send_byte(hex_char(sum[7:4], flaw == 1));
    if (flaw == 0) begin
      send_byte(hex_char(sum[3:0] + 4'd1, 1'b0));
    end else if (flaw != 6) begin
      send_byte(hex_char(sum[3:0], flaw == 1));
    end
    if (flaw == 2) begin
      send_byte(hex_char(4'($urandom_range(0, 15)), 1'b0));
    end
    if ($urandom_range(0, 9) < 7) begin
      send_byte(CHAR_CR);
    end
    send_byte(CHAR_LF);
  endtask

  // body runs from just under to just past the sentence limit
  task automatic send_long_sentence();
    int n;
    n = $urandom_range(MaxSentence - 2, MaxSentence + 2);
    send_byte(CHAR_DOLLAR);
    repeat (n) send_byte(body_char());
    send_byte(CHAR_LF);
  endtask

  task automatic send_bad_burst();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 1) begin
      clock_ms = window_ms + $urandom_range(0, 40);
    end
    repeat ($urandom_range(3, 30)) begin
      if ($urandom_range(0, 5) == 0) begin
        do c = 8'($urandom_range(0, 8'h7F));
        while (c == CHAR_DOLLAR);
      end else begin
        c = 8'($urandom_range(8'h80, 8'hFF));
      end
      clock_ms = clock_ms + $urandom_range(0, 1);
      offer_byte(c, clock_ms, 1'b0, NoRes);
    end
  endtask

  initial begin : run_stimulus
    int idx;
    int phase;
    int target;
    int pick;
    bit held;
    bit paused;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'd0;
    rx_ch.now_ms = 32'd0;
    held = 1'b0;
    paused = 1'b0;
    rate_limit = LIMIT_RESET;
    cap_active = 1'b0;
    body_len = 8'd0;
    sent_start_ms = 32'd0;
    body_xor = 8'd0;
    star_hit = 1'b0;
    hex_count = 2'd0;
    body_bad = 1'b0;
    bad_starts = 16'd0;
    window_ms = 32'd0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (idx = 0; idx < ScriptLen; idx++) begin
      offer_byte(DirectedScript[idx].rx_byte, DirectedScript[idx].now_ms,
                 DirectedScript[idx].pinned, DirectedScript[idx].res);
    end
    clock_ms = 32'd30;

    for (phase = 0; phase < 5; phase++) begin
      drain_results();
      case (phase)
        1: write_limit(10'd0);
        2: write_limit(10'd1023);
        3: write_limit(10'($urandom_range(1, 999)));
        4: write_limit(10'd1000);
        default: ;
      endcase
      rx_gaps_on = (phase != 4);
      res_stalls_on = (phase != 4);
      if (phase == 1 || phase == 3) begin
        send_long_sentence();
      end
      target = items_sent + PhaseItems;
      while (items_sent < target) begin
        if (phase == 1 && !held && items_sent > target - PhaseItems / 2) begin
          // long hold on the result side while items keep coming
          rx_gaps_on = 1'b0;
          res_hold_req = 1'b1;
          repeat (30) send_byte(8'($urandom_range(0, 255)));
          rx_gaps_on = 1'b1;
          held = 1'b1;
        end
        if (phase == 2 && !paused && items_sent > target - PhaseItems / 2) begin
          drain_results();
          paused = 1'b1;
        end
        if (phase != 4 && $urandom_range(0, 9) == 0) begin
          rx_gaps_on = !rx_gaps_on;
          res_stalls_on = 1'($urandom_range(0, 1));
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          send_sentence(($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 6)) : -1);
        end else if (pick < 80) begin
          repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_bad_burst();
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
